// File: hw/rtl/plas_pkg.sv
// Shared types and constants of the polyline arc-length sampler.
package plas_pkg;

  localparam int MaxPoints = 256;
  localparam int AddrW     = 8;
  localparam int CntW      = 9;
  localparam int LenW      = 34;
  localparam int AccW      = 67;
  localparam int RemW      = 36;
  localparam int CurW      = 44;
  localparam int StepW     = 7;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_CLOSED = 2'd0;
  localparam logic [1:0] REG_COUNT  = 2'd1;
  localparam logic [1:0] REG_LENGTH = 2'd2;

  // Item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Vertex index meaning no source vertex.
  localparam logic [15:0] VTX_NONE = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_WRAP,
    ST_RDS,
    ST_RDE,
    ST_DIFF,
    ST_SQ,
    ST_ROOT,
    ST_CHK,
    ST_MUL,
    ST_LDIV,
    ST_RDP,
    ST_PT,
    ST_OUT
  } state_t;

endpackage

// File: hw/rtl/plas_if.sv
// Handshake interfaces for the input and result channels.
interface plas_in_if;
  import plas_pkg::*;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  slot;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [15:0] point_vertex;
  logic [31:0] query_arc;
  modport source (output valid, kind, slot, point_x, point_y, point_vertex, query_arc,
                  input ready);
  modport sink (input valid, kind, slot, point_x, point_y, point_vertex, query_arc,
                output ready);
endinterface

interface plas_out_if;
  import plas_pkg::*;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [31:0] sampled_arc;
  logic [31:0] sample_x;
  logic [31:0] sample_y;
  logic [15:0] sample_vertex;
  modport source (output valid, valid_res, sampled_arc, sample_x, sample_y, sample_vertex,
                  input ready);
  modport sink (input valid, valid_res, sampled_arc, sample_x, sample_y, sample_vertex,
                output ready);
endinterface

// File: hw/rtl/polyline_arc_length_sampler.sv
// Polyline arc-length sampler: point store, segment walker and shared arithmetic unit.
// A load item is taken while idle and the block stays ready. One item at a time: after a
// query the block takes nothing until its result item has been taken by the sink.
// A query result is offered once the closed-path wrap, the walk over the segments (two
// squarings and a square root for each segment walked) and any interpolation (a multiply
// and a divide per axis) are done.
// Synchronous active-low reset clears config, state and out valid, not datapath or store.
module polyline_arc_length_sampler (
  input  logic         clk,
  input  logic         rst_n,
  plas_in_if.sink      in_ch,
  plas_out_if.source   out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import plas_pkg::*;

  // Configuration registers.
  logic              closed_r;
  logic [CntW-1:0]   count_r;
  logic [31:0]       total_r;

  // Point store.
  logic [31:0]       x_mem [MaxPoints];
  logic [31:0]       y_mem [MaxPoints];
  logic [15:0]       v_mem [MaxPoints];
  logic [AddrW-1:0]  rd_addr;
  logic [31:0]       rd_x_r, rd_y_r;
  logic [15:0]       rd_v_r;

  // Sequencer and datapath registers.
  state_t            state_r, state_nxt;
  logic [31:0]       arc_r, arc_nxt;
  logic              neg_r, neg_nxt;
  logic [CntW-1:0]   i_r, i_nxt;
  logic [CurW-1:0]   cursor_r, cursor_nxt;
  logic [LenW-1:0]   len_r, len_nxt;
  logic [31:0]       sx_r, sx_nxt, sy_r, sy_nxt, ex_r, ex_nxt, ey_r, ey_nxt;
  logic [AccW-1:0]   acc_r, acc_nxt, opa_r, opa_nxt;
  logic [LenW-1:0]   opb_r, opb_nxt, den_r, den_nxt, d_r, d_nxt;
  logic [RemW-1:0]   rem_r, rem_nxt;
  logic [StepW-1:0]  cnt_r, cnt_nxt;
  logic              axis_r, axis_nxt;
  logic [AddrW-1:0]  pt_r, pt_nxt;
  logic [31:0]       res_arc_r, res_arc_nxt, rx_r, rx_nxt;

  // Output register.
  logic              o_valid_r, o_valid_nxt, o_vres_r, o_vres_nxt;
  logic [31:0]       o_arc_r, o_arc_nxt, o_x_r, o_x_nxt, o_y_r, o_y_nxt;
  logic [15:0]       o_v_r, o_v_nxt;

  // Combinational helpers.
  logic              in_acc, cfg_wr;
  logic [CntW-1:0]   n_pts, n_segs, i_inc, nx;
  logic [31:0]       s_sel, e_sel, lerp_res, wrap_arc, q_last;
  logic [32:0]       dlt, mag;
  logic              dneg;
  logic [RemW-1:0]   div_sh, div_sub, sq_sh, sq_trial;
  logic              div_ge, sq_ge;
  logic [CurW-1:0]   lim, dd, d_clamped, arc_w;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_r <= 1'b0;
      count_r  <= '0;
      total_r  <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CLOSED: closed_r <= pwdata[0];
        REG_COUNT:  count_r  <= pwdata[CntW-1:0];
        REG_LENGTH: total_r  <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_CLOSED: prdata = {31'd0, closed_r};
      REG_COUNT:  prdata = {{(32-CntW){1'b0}}, count_r};
      REG_LENGTH: prdata = total_r;
      default:    prdata = '0;
    endcase
  end

  // Point store: written by load items, read one entry a cycle.
  assign in_acc = in_ch.valid & in_ch.ready;
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.kind == KIND_LOAD) begin
      x_mem[in_ch.slot] <= in_ch.point_x;
      y_mem[in_ch.slot] <= in_ch.point_y;
      v_mem[in_ch.slot] <= in_ch.point_vertex;
    end
    rd_x_r <= x_mem[rd_addr];
    rd_y_r <= y_mem[rd_addr];
    rd_v_r <= v_mem[rd_addr];
  end

  // Point and segment counts.
  assign n_pts  = (count_r > CntW'(MaxPoints)) ? CntW'(MaxPoints) : count_r;
  assign n_segs = closed_r ? n_pts : n_pts - 1'b1;
  assign i_inc  = i_r + 1'b1;
  assign nx     = (i_inc == n_pts) ? '0 : i_inc;

  // Difference along the current axis and its magnitude.
  assign s_sel    = axis_r ? sy_r : sx_r;
  assign e_sel    = axis_r ? ey_r : ex_r;
  assign dlt      = {e_sel[31], e_sel} - {s_sel[31], s_sel};
  assign dneg     = dlt[32];
  assign mag      = dneg ? (~dlt + 33'd1) : dlt;
  assign lerp_res = dneg ? (s_sel - acc_r[31:0]) : (s_sel + acc_r[31:0]);

  // Restoring divide step, used for the wrap and the interpolation.
  assign div_sh  = {rem_r[RemW-2:0], acc_r[AccW-1]};
  assign div_ge  = div_sh >= {{(RemW-LenW){1'b0}}, den_r};
  assign div_sub = div_sh - {{(RemW-LenW){1'b0}}, den_r};

  // Quotient as it stands after the current divide step.
  assign q_last = {acc_r[30:0], div_ge};

  // Square-root step, two radicand bits at a time.
  assign sq_sh    = {rem_r[RemW-3:0], acc_r[AccW-2:AccW-3]};
  assign sq_trial = {len_r, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  // Wrapped arc with the snap at both ends.
  always_comb begin
    wrap_arc = rem_r[31:0];
    if (neg_r && wrap_arc != '0) wrap_arc = total_r - wrap_arc;
    if (wrap_arc >= total_r - 32'd1 || wrap_arc == '0) wrap_arc = '0;
  end

  // Segment match and offset.
  assign arc_w     = {{(CurW-32){1'b0}}, arc_r};
  assign lim       = cursor_r + {{(CurW-LenW){1'b0}}, len_r} + 1'b1;
  assign dd        = (arc_w > cursor_r) ? (arc_w - cursor_r) : '0;
  assign d_clamped = (dd > {{(CurW-LenW){1'b0}}, len_r}) ?
                     {{(CurW-LenW){1'b0}}, len_r} : dd;

  // Sequencer state and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      o_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      o_valid_r <= o_valid_nxt;
    end
    arc_r     <= arc_nxt;
    neg_r     <= neg_nxt;
    i_r       <= i_nxt;
    cursor_r  <= cursor_nxt;
    len_r     <= len_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    ex_r      <= ex_nxt;
    ey_r      <= ey_nxt;
    acc_r     <= acc_nxt;
    opa_r     <= opa_nxt;
    opb_r     <= opb_nxt;
    den_r     <= den_nxt;
    d_r       <= d_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    axis_r    <= axis_nxt;
    pt_r      <= pt_nxt;
    res_arc_r <= res_arc_nxt;
    rx_r      <= rx_nxt;
    o_vres_r  <= o_vres_nxt;
    o_arc_r   <= o_arc_nxt;
    o_x_r     <= o_x_nxt;
    o_y_r     <= o_y_nxt;
    o_v_r     <= o_v_nxt;
  end

  // Next state and datapath control.
  always_comb begin
    state_nxt   = state_r;
    arc_nxt     = arc_r;
    neg_nxt     = neg_r;
    i_nxt       = i_r;
    cursor_nxt  = cursor_r;
    len_nxt     = len_r;
    sx_nxt      = sx_r;
    sy_nxt      = sy_r;
    ex_nxt      = ex_r;
    ey_nxt      = ey_r;
    acc_nxt     = acc_r;
    opa_nxt     = opa_r;
    opb_nxt     = opb_r;
    den_nxt     = den_r;
    d_nxt       = d_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    axis_nxt    = axis_r;
    pt_nxt      = pt_r;
    res_arc_nxt = res_arc_r;
    rx_nxt      = rx_r;
    o_valid_nxt = o_valid_r;
    o_vres_nxt  = o_vres_r;
    o_arc_nxt   = o_arc_r;
    o_x_nxt     = o_x_r;
    o_y_nxt     = o_y_r;
    o_v_nxt     = o_v_r;
    rd_addr     = i_r[AddrW-1:0];
    in_ch.ready = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && in_ch.kind == KIND_QUERY) begin
          i_nxt      = '0;
          cursor_nxt = '0;
          if (n_pts == '0) begin
            o_valid_nxt = 1'b1;
            o_vres_nxt  = 1'b0;
            o_arc_nxt   = '0;
            o_x_nxt     = '0;
            o_y_nxt     = '0;
            o_v_nxt     = VTX_NONE;
            state_nxt   = ST_OUT;
          end else if (total_r == '0) begin
            pt_nxt      = '0;
            res_arc_nxt = '0;
            state_nxt   = ST_RDP;
          end else if (closed_r) begin
            neg_nxt   = in_ch.query_arc[31];
            acc_nxt   = {(in_ch.query_arc[31] ? (~in_ch.query_arc + 32'd1) : in_ch.query_arc),
                         {(AccW-32){1'b0}}};
            den_nxt   = {{(LenW-32){1'b0}}, total_r};
            rem_nxt   = '0;
            cnt_nxt   = StepW'(32);
            state_nxt = ST_DIV;
          end else begin
            if (in_ch.query_arc[31])          arc_nxt = '0;
            else if (in_ch.query_arc > total_r) arc_nxt = total_r;
            else                               arc_nxt = in_ch.query_arc;
            state_nxt = ST_RDS;
          end
        end
      end

      // Remainder of the arc magnitude by the total length.
      ST_DIV: begin
        rem_nxt = div_ge ? div_sub : div_sh;
        acc_nxt = {acc_r[AccW-2:0], div_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == StepW'(1)) state_nxt = ST_WRAP;
      end

      ST_WRAP: begin
        arc_nxt   = wrap_arc;
        state_nxt = ST_RDS;
      end

      // Fetch the segment start, or finish when no segment matched.
      ST_RDS: begin
        if (i_r == n_segs) begin
          if (closed_r) begin
            pt_nxt      = '0;
            res_arc_nxt = '0;
          end else begin
            pt_nxt      = AddrW'(n_pts - 1'b1);
            res_arc_nxt = total_r;
          end
          state_nxt = ST_RDP;
        end else begin
          state_nxt = ST_RDE;
        end
      end

      ST_RDE: begin
        rd_addr   = nx[AddrW-1:0];
        sx_nxt    = rd_x_r;
        sy_nxt    = rd_y_r;
        state_nxt = ST_DIFF;
      end

      ST_DIFF: begin
        ex_nxt    = rd_x_r;
        ey_nxt    = rd_y_r;
        acc_nxt   = '0;
        axis_nxt  = 1'b0;
        cnt_nxt   = '0;
        state_nxt = ST_SQ;
      end

      // Sum of squares by shift and add, x then y.
      ST_SQ: begin
        if (cnt_r == '0) begin
          opa_nxt = {{(AccW-33){1'b0}}, mag};
          opb_nxt = {1'b0, mag};
          cnt_nxt = StepW'(33);
        end else begin
          if (opb_r[0]) acc_nxt = acc_r + opa_r;
          opa_nxt = {opa_r[AccW-2:0], 1'b0};
          opb_nxt = {1'b0, opb_r[LenW-1:1]};
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == StepW'(1)) begin
            if (!axis_r) begin
              axis_nxt = 1'b1;
              cnt_nxt  = '0;
            end else begin
              rem_nxt   = '0;
              len_nxt   = '0;
              cnt_nxt   = StepW'(33);
              state_nxt = ST_ROOT;
            end
          end
        end
      end

      // Integer square root, one result bit a cycle.
      ST_ROOT: begin
        rem_nxt = sq_ge ? (sq_sh - sq_trial) : sq_sh;
        len_nxt = {len_r[LenW-2:0], sq_ge};
        acc_nxt = {acc_r[AccW-3:0], 2'b00};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == StepW'(1)) state_nxt = ST_CHK;
      end

      // Match the arc against this segment.
      ST_CHK: begin
        if (len_r == '0) begin
          i_nxt     = i_inc;
          state_nxt = ST_RDS;
        end else if (arc_w <= lim) begin
          if (d_clamped == '0) begin
            pt_nxt      = i_r[AddrW-1:0];
            res_arc_nxt = cursor_r[31:0];
            state_nxt   = ST_RDP;
          end else if (d_clamped == {{(CurW-LenW){1'b0}}, len_r}) begin
            pt_nxt      = nx[AddrW-1:0];
            res_arc_nxt = cursor_r[31:0] + len_r[31:0];
            state_nxt   = ST_RDP;
          end else begin
            d_nxt       = d_clamped[LenW-1:0];
            res_arc_nxt = cursor_r[31:0] + d_clamped[31:0];
            axis_nxt    = 1'b0;
            cnt_nxt     = '0;
            state_nxt   = ST_MUL;
          end
        end else begin
          cursor_nxt = cursor_r + {{(CurW-LenW){1'b0}}, len_r};
          i_nxt      = i_inc;
          state_nxt  = ST_RDS;
        end
      end

      // Magnitude of the axis difference times the offset.
      ST_MUL: begin
        if (cnt_r == '0) begin
          acc_nxt = '0;
          opa_nxt = {{(AccW-33){1'b0}}, mag};
          opb_nxt = d_r;
          cnt_nxt = StepW'(LenW);
        end else begin
          if (opb_r[0]) acc_nxt = acc_r + opa_r;
          opa_nxt = {opa_r[AccW-2:0], 1'b0};
          opb_nxt = {1'b0, opb_r[LenW-1:1]};
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == StepW'(1)) begin
            rem_nxt   = '0;
            den_nxt   = len_r;
            cnt_nxt   = StepW'(AccW);
            state_nxt = ST_LDIV;
          end
        end
      end

      // Product divided by the segment length, then step from the start point.
      ST_LDIV: begin
        rem_nxt = div_ge ? div_sub : div_sh;
        acc_nxt = {acc_r[AccW-2:0], div_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == StepW'(1)) begin
          cnt_nxt = '0;
          if (!axis_r) begin
            axis_nxt  = 1'b1;
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end

      ST_RDP: begin
        rd_addr   = pt_r;
        state_nxt = ST_PT;
      end

      ST_PT: begin
        o_valid_nxt = 1'b1;
        o_vres_nxt  = 1'b1;
        o_arc_nxt   = res_arc_r;
        o_x_nxt     = rd_x_r;
        o_y_nxt     = rd_y_r;
        o_v_nxt     = rd_v_r;
        state_nxt   = ST_OUT;
      end

      ST_OUT: begin
        if (!o_valid_r) begin
          // Interpolated result: the divide has just finished the y axis.
          o_valid_nxt = 1'b1;
          o_vres_nxt  = 1'b1;
          o_arc_nxt   = res_arc_r;
          o_x_nxt     = rx_r;
          o_y_nxt     = lerp_res;
          o_v_nxt     = VTX_NONE;
        end else if (out_ch.ready) begin
          o_valid_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Keep the x result once its divide completes.
    if (state_r == ST_LDIV && cnt_r == StepW'(1) && !axis_r) begin
      rx_nxt = dneg ? (sx_r - q_last) : (sx_r + q_last);
    end
  end

  assign out_ch.valid         = o_valid_r;
  assign out_ch.valid_res     = o_vres_r;
  assign out_ch.sampled_arc   = o_arc_r;
  assign out_ch.sample_x      = o_x_r;
  assign out_ch.sample_y      = o_y_r;
  assign out_ch.sample_vertex = o_v_r;

endmodule

// File: hw/rtl/plas_chk.sv
// Port checker for the polyline arc-length sampler and its bind.
module plas_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_valid_res,
  input logic [31:0] out_sample_x,
  input logic [15:0] out_sample_vertex
);
  import plas_pkg::*;

  // A result waiting for the sink stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before it was taken");

  // No new item is taken while a result is pending.
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  // A query makes the block busy in the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_QUERY |=> !in_ready)
    else $error("block still ready after a query item");

  // An empty store gives the fixed invalid result.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_sample_vertex == VTX_NONE && out_sample_x == '0)
    else $error("invalid result carries a point");

endmodule

bind polyline_arc_length_sampler plas_chk u_plas_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_kind           (in_ch.kind),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_valid_res     (out_ch.valid_res),
  .out_sample_x      (out_ch.sample_x),
  .out_sample_vertex (out_ch.sample_vertex)
);

// File: verif/plas_checker.sv
// Checker for the polyline arc-length sampler: predicts every query result and compares it.
module plas_checker
  import plas_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  plas_in_if          in_ch,
  plas_out_if         out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic        valid_res;
    logic [31:0] arc;
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] vtx;
  } sample_t;

  // Own copy of the point store and the registers.
  logic [31:0] x_pts [MaxPoints];
  logic [31:0] y_pts [MaxPoints];
  logic [15:0] v_pts [MaxPoints];
  logic        is_closed;
  logic [8:0]  n_points;
  logic [31:0] total_len;

  sample_t expected_samples[$];

  // Floor of the Euclidean length of a segment, in LSB.
  function automatic logic [33:0] seg_len(input longint dx, input longint dy);
    logic [65:0] sum;
    logic [33:0] r, c;
    logic [67:0] sq;
    logic [63:0] ax, ay;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    sum = {2'b0, ax} * {2'b0, ax} + {2'b0, ay} * {2'b0, ay};
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      sq = {34'b0, c} * {34'b0, c};
      if (sq <= {2'b0, sum}) r = c;
    end
    return r;
  endfunction

  // One axis of the interpolation, truncated toward the start point.
  function automatic logic [31:0] lerp(input longint s, input longint e,
                                       input logic [63:0] d, input logic [63:0] len);
    longint delta;
    logic [127:0] mag, step;
    delta = e - s;
    mag = delta < 0 ? -delta : delta;
    step = (mag * d) / len;
    return delta < 0 ? 32'(s - longint'(step)) : 32'(s + longint'(step));
  endfunction

  function automatic sample_t stored_point(input logic [63:0] arc, input int k);
    return '{1'b1, arc[31:0], x_pts[k], y_pts[k], v_pts[k]};
  endfunction

  // Wrap or clamp the arc, then walk the segments to the one it falls on.
  function automatic sample_t predict_sample(input logic [31:0] query);
    int n, segs, nx;
    longint arc, total, sx, sy, ex, ey;
    logic [63:0] cursor, len, d;
    n = n_points > MaxPoints ? MaxPoints : n_points;
    if (n == 0) return '{1'b0, 32'd0, 32'd0, 32'd0, VTX_NONE};
    total = longint'(total_len);
    if (total == 0) return stored_point(0, 0);
    arc = longint'(signed'(query));
    if (is_closed) begin
      arc = arc % total;
      if (arc < 0) arc += total;
      if (arc >= total - 1 || arc < 1) arc = 0;
    end else begin
      if (arc < 0) arc = 0;
      if (arc > total) arc = total;
    end
    segs = is_closed ? n : n - 1;
    cursor = '0;
    for (int i = 0; i < segs; i++) begin
      nx = (i + 1) % n;
      sx = longint'(signed'(x_pts[i]));
      sy = longint'(signed'(y_pts[i]));
      ex = longint'(signed'(x_pts[nx]));
      ey = longint'(signed'(y_pts[nx]));
      len = 64'(seg_len(ex - sx, ey - sy));
      if (len != 0) begin
        if (64'(arc) <= cursor + len + 1) begin
          d = 64'(arc) > cursor ? 64'(arc) - cursor : 64'd0;
          if (d > len) d = len;
          if (d == 0) return stored_point(cursor, i);
          if (d == len) return stored_point(cursor + len, nx);
          return '{1'b1, 32'(cursor + d), lerp(sx, ex, d, len), lerp(sy, ey, d, len),
                   VTX_NONE};
        end
        cursor += len;
      end
    end
    if (is_closed) return stored_point(0, 0);
    return stored_point(64'(total), n - 1);
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch in %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  // Register writes, loads and queries on the way in; results on the way out.
  always @(posedge clk) begin
    sample_t got, want;
    if (!rst_n) begin
      is_closed <= 1'b0;
      n_points  <= '0;
      total_len <= '0;
      expected_samples.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_CLOSED: is_closed <= pwdata[0];
          REG_COUNT:  n_points  <= pwdata[8:0];
          REG_LENGTH: total_len <= pwdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.kind == KIND_LOAD) begin
          x_pts[in_ch.slot] <= in_ch.point_x;
          y_pts[in_ch.slot] <= in_ch.point_y;
          v_pts[in_ch.slot] <= in_ch.point_vertex;
        end else begin
          expected_samples = {expected_samples, predict_sample(in_ch.query_arc)};
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.valid_res, out_ch.sampled_arc, out_ch.sample_x, out_ch.sample_y,
                out_ch.sample_vertex};
        if (expected_samples.size() == 0) begin
          $display("result item with no query outstanding");
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (got.valid_res != want.valid_res) begin
            report("valid_res", 32'(got.valid_res), 32'(want.valid_res));
          end
          if (got.arc != want.arc) report("sampled_arc", got.arc, want.arc);
          if (got.x != want.x) report("sample_x", got.x, want.x);
          if (got.y != want.y) report("sample_y", got.y, want.y);
          if (got.vtx != want.vtx) report("sample_vertex", 32'(got.vtx), 32'(want.vtx));
        end
      end
    end
    pending = expected_samples.size();
  end

endmodule

// File: verif/tb_top.sv
// Top of the sampler testbench: clock, reset, stimulus, receiver stalls and the verdict.
module tb_top;
  import plas_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          errors, pending, items;
  int          burst_left, gap_left, stall_mode, mode_left;

  plas_in_if  in_ch ();
  plas_out_if out_ch ();

  polyline_arc_length_sampler dut (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  plas_checker u_checker (
    .clk, .rst_n, .in_ch, .out_ch, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver stalls: always ready, random, or mostly stalled, in changing stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      mode_left    <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= $urandom_range(0, 1);
        default: out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait for every outstanding result, then let the block settle before reconfiguring.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_path(input logic closed, input int count, input logic [31:0] len);
    drain();
    reg_write(REG_CLOSED, 32'(closed));
    reg_write(REG_COUNT, 32'(count));
    reg_write(REG_LENGTH, len);
  endtask

  // Send one item, with bursts and gaps on the sender side. Called at a rising edge.
  task automatic send(input logic kind, input logic [7:0] slot, input logic [31:0] px,
                      input logic [31:0] py, input logic [15:0] pv, input logic [31:0] qa);
    if (burst_left == 0) begin
      gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 10);
    end
    if (gap_left > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.slot         <= slot;
    in_ch.point_x      <= px;
    in_ch.point_y      <= py;
    in_ch.point_vertex <= pv;
    in_ch.query_arc    <= qa;
    do @(posedge clk); while (!in_ch.ready);
    // The accepting edge is also where the next item, a gap or a drain takes over.
    items++;
  endtask

  task automatic load(input int slot, input logic [31:0] px, input logic [31:0] py,
                      input logic [15:0] pv);
    send(KIND_LOAD, 8'(slot), px, py, pv, $urandom);
  endtask

  task automatic query(input logic [31:0] qa);
    send(KIND_QUERY, 8'($urandom), $urandom, $urandom, 16'($urandom), qa);
  endtask

  function automatic logic [15:0] rand_vertex();
    return $urandom_range(0, 5) == 0 ? VTX_NONE : 16'($urandom_range(0, 32767));
  endfunction

  function automatic logic [31:0] rand_coord(input int spread);
    if (spread == 0) return $urandom;
    return 32'($urandom_range(0, 32'h100000) - 32'h80000);
  endfunction

  initial begin
    int count, spread;
    logic [31:0] len;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.kind = KIND_LOAD; in_ch.slot = '0;
    in_ch.point_x = '0; in_ch.point_y = '0; in_ch.point_vertex = '0; in_ch.query_arc = '0;
    items = 0; burst_left = 0; gap_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Empty store with the reset settings.
    query(32'h0001_0000);

    // Unit square with a repeated corner, so one segment has zero length.
    load(0, 32'h0, 32'h0, 16'd0);
    load(1, 32'h1_0000, 32'h0, 16'd1);
    load(2, 32'h1_0000, 32'h0, 16'd2);
    load(3, 32'h1_0000, 32'h1_0000, 16'd3);
    load(4, 32'h0, 32'h1_0000, VTX_NONE);
    set_path(1'b0, 5, 32'h4_0000);
    query(32'hFFFF_FFFB);
    query(32'h0);
    query(32'h8000);
    query(32'h1_0000);
    query(32'h1_0001);
    query(32'h2_8001);
    query(32'h7FFF_FFFF);
    set_path(1'b1, 5, 32'h4_0000);
    query(32'h3_FFFF);
    query(32'hFFFF_8000);
    query(32'h4_0000);
    query(32'h8000_0000);
    query(32'h3_C000);
    set_path(1'b1, 5, 32'h0);
    query(32'h1234_5678);
    set_path(1'b0, 5, 32'hFFFF_FFFF);
    query(32'h7FFF_FFFF);

    // Coordinates at the extremes of their range.
    load(5, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF);
    load(6, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0);
    set_path(1'b1, 7, 32'hFFFF_FFFF);
    query(32'h7FFF_FFFF);
    query(32'h0004_0000);

    // Random paths: mostly small coordinates and few points.
    while (items < 100) begin
      count  = $urandom_range(1, 8);
      spread = $urandom_range(0, 4);
      for (int i = 0; i < count; i++) begin
        load(i, rand_coord(spread), rand_coord(spread), rand_vertex());
      end
      case ($urandom_range(0, 5))
        0:       len = '0;
        1:       len = 32'hFFFF_FFFF;
        default: len = $urandom_range(1, count * 32'h10_0000);
      endcase
      set_path(1'($urandom_range(0, 1)), count, len);
      repeat ($urandom_range(2, 8)) begin
        query($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, len));
      end
      // Hold the sender off until every result has come back.
      if ($urandom_range(0, 3) == 0) drain();
    end

    // A longer path, walked a few times.
    for (int i = 0; i < 24; i++) begin
      load(i, rand_coord(1), rand_coord(1), rand_vertex());
    end
    set_path(1'b0, 24, 32'h0080_0000);
    query($urandom_range(0, 32'h0080_0000));
    query(32'h7FFF_FFFF);
    set_path(1'b1, 24, $urandom_range(1, 32'h0080_0000));
    query($urandom);

    drain();
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hung run.
  initial begin
    #40000000;
    $display("status: fail");
    $finish;
  end

endmodule
